// ===== rtl/chd_pkg.sv =====
// chd_pkg: shared constants, register map and arctangent table of the compass heading block
// no dependencies
package chd_pkg;

    // register indexes on the configuration port (byte address / 4)
    localparam logic [2:0] REG_OFFSET_X  = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [2:0] REG_SCALE_X   = 3'd2;
    localparam logic [2:0] REG_SCALE_Y   = 3'd3;
    localparam logic [2:0] REG_REF_ANGLE = 3'd4;

    // widths of the datapath
    localparam int PROD_W  = 34;   // corrected axis, 18b signed times 16b unsigned
    localparam int VEC_W   = 37;   // cordic vector with gain headroom
    localparam int ANG_W   = 27;   // cordic angle, degrees * 65536
    localparam int HEAD_W  = 28;   // per-sample heading before rounding
    localparam int SUM_W   = 24;
    localparam int DVD_W   = 25;

    localparam logic signed [ANG_W-1:0]  Z_180    = 27'sd11796480;
    localparam logic signed [HEAD_W-1:0] H_180    = 28'sd11796480;
    localparam logic signed [HEAD_W-1:0] H_360    = 28'sd23592960;
    localparam logic signed [19:0]       HEAD_MAX = 20'sd46080;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/compass_heading_average.sv =====
// compass_heading_average: top level, sequencer, heading accumulator and register file
// depends on chd_pkg, chd_mult, chd_cordic, chd_div
//
// usage
//   s_ channel: one beat carries one raw x/y magnetometer sample (s_raw_x, s_raw_y)
//   m_ channel: one beat carries the mean heading of a group, degrees * 256
//   apb port: offsets, soft-iron scales and reference angle, written while idle
// processing of one sample
//   accept, then the bit-serial scale multipliers (16 scale bits, one per cycle),
//   then the cordic, whose micro-rotation loop runs CORDIC_STEPS steps for a nonzero
//   vector, then the heading is formed and accumulated
// every SAMPLES_PER_HEADING samples the sum goes to the serial divider, which forms
//   25 quotient bits before the block is idle again; the result beat then passes
//   through the pending flag into the output register
// stall: a result waits in the output register, and the next sample is still
//   taken; only a second result finding the register full holds the block
// reset: configuration registers go to their defaults, sum and sample count clear, no beat pending
module compass_heading_average #(
    parameter int SAMPLES_PER_HEADING = 10,
    parameter int CORDIC_STEPS        = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // sample channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_raw_x,
    input  logic signed [15:0] s_raw_y,
    // heading channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_heading,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_CORD = 6'b000100,
        ST_HEAD = 6'b001000,
        ST_SUM  = 6'b010000,
        ST_DIV  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [16:0] offset_x_reg, offset_y_reg;
    logic        [15:0] scale_x_reg, scale_y_reg;
    logic        [16:0] ref_angle_reg;
    logic               cfg_wr;

    // datapath
    logic signed [17:0] ax_reg, ay_reg, ax_next, ay_next;
    logic signed [chd_pkg::PROD_W-1:0] px, py;
    logic signed [chd_pkg::ANG_W-1:0]  z;
    logic signed [chd_pkg::HEAD_W-1:0] h_reg, h_next, h_raw;
    logic signed [chd_pkg::HEAD_W-1:0] h_rnd;
    logic signed [19:0]                hs;
    logic signed [chd_pkg::SUM_W-1:0]  sum_reg, sum_next, sum_add;
    logic [5:0]  count_reg, count_next;
    logic [6:0]  count_inc;
    logic        mul_start, mul_done, mul_done_y, cord_start, cord_done;
    logic        div_start, div_done, div_pend_reg, div_pend_next;
    logic signed [16:0] quot;
    logic signed [16:0] head_reg, head_next;
    logic        m_valid_reg, m_valid_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg  <= -17'sd7824;
            offset_y_reg  <= -17'sd4048;
            scale_x_reg   <= 16'd15308;
            scale_y_reg   <= 16'd17623;
            ref_angle_reg <= 17'd26254;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                chd_pkg::REG_OFFSET_X:  offset_x_reg  <= pwdata[16:0];
                chd_pkg::REG_OFFSET_Y:  offset_y_reg  <= pwdata[16:0];
                chd_pkg::REG_SCALE_X:   scale_x_reg   <= pwdata[15:0];
                chd_pkg::REG_SCALE_Y:   scale_y_reg   <= pwdata[15:0];
                chd_pkg::REG_REF_ANGLE: ref_angle_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            chd_pkg::REG_OFFSET_X:  prdata = 32'(offset_x_reg);
            chd_pkg::REG_OFFSET_Y:  prdata = 32'(offset_y_reg);
            chd_pkg::REG_SCALE_X:   prdata = {16'd0, scale_x_reg};
            chd_pkg::REG_SCALE_Y:   prdata = {16'd0, scale_y_reg};
            chd_pkg::REG_REF_ANGLE: prdata = {15'd0, ref_angle_reg};
            default:                prdata = '0;
        endcase
    end

    // hard-iron correction in half counts, then serial soft-iron scaling
    // the multipliers load the corrected axis in the accept cycle
    chd_mult u_mult_x (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .mcand(ax_next), .mplier(scale_x_reg), .done(mul_done), .prod(px)
    );
    chd_mult u_mult_y (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .mcand(ay_next), .mplier(scale_y_reg), .done(mul_done_y), .prod(py)
    );

    chd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cord_start),
        .x_in(px), .y_in(py), .done(cord_done), .angle(z)
    );

    chd_div #(.N(SAMPLES_PER_HEADING)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .sum(sum_next), .done(div_done), .quot(quot)
    );

    assign s_ready = (state_reg == ST_IDLE) && !(div_pend_reg && m_valid_reg);

    always_comb begin
        // heading = reference - atan2, folded once by a full turn when above 180 degrees
        h_raw = $signed({3'b000, ref_angle_reg, 8'h00}) - chd_pkg::HEAD_W'(z);
        // round to degrees * 256, half up, then clamp
        h_rnd = (h_reg + 28'sd128) >>> 8;
        if (h_rnd > 28'(chd_pkg::HEAD_MAX)) begin
            hs = chd_pkg::HEAD_MAX;
        end else if (h_rnd < -28'(chd_pkg::HEAD_MAX)) begin
            hs = -chd_pkg::HEAD_MAX;
        end else begin
            hs = h_rnd[19:0];
        end
        sum_add   = sum_reg + chd_pkg::SUM_W'(hs);
        count_inc = {1'b0, count_reg} + 7'd1;

        state_next    = state_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        h_next        = h_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        mul_start     = 1'b0;
        cord_start    = 1'b0;
        div_start     = 1'b0;
        div_pend_next = div_pend_reg;
        head_next     = head_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (div_pend_reg && !m_valid_next) begin
            // quotient parked in the divider until the output register frees up
            head_next     = quot;
            m_valid_next  = 1'b1;
            div_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    ax_next    = $signed({s_raw_x[15], s_raw_x, 1'b0}) - 18'(offset_x_reg);
                    ay_next    = $signed({s_raw_y[15], s_raw_y, 1'b0}) - 18'(offset_y_reg);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                mul_start  = 1'b0;
                if (mul_done) begin
                    cord_start = 1'b1;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                if (cord_done) begin
                    h_next     = (h_raw > chd_pkg::H_180) ? h_raw - chd_pkg::H_360 : h_raw;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (count_inc == 7'(SAMPLES_PER_HEADING)) begin
                    sum_next   = sum_add;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    sum_next   = sum_add;
                    count_next = count_inc[5:0];
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                sum_next   = '0;
                count_next = '0;
                if (div_done) begin
                    div_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && s_valid && s_ready) begin
            mul_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            div_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            div_pend_reg <= div_pend_next;
        end
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        h_reg    <= h_next;
        head_reg <= head_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_heading = head_reg;

    // both multipliers run in lock step
    a_mul_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done == mul_done_y)
        else $error("scale multipliers out of step");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside its phase");

    a_cord_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cord_done |-> state_reg == ST_CORD)
        else $error("cordic finished outside its phase");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> 7'(count_reg) < 7'(SAMPLES_PER_HEADING))
        else $error("sample count reached group size without emitting");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_MUL)
        else $error("accepted sample did not start the multipliers");
endmodule

// ===== rtl/chd_mult.sv =====
// chd_mult: bit-serial shift-add multiplier, 18b signed by 16b unsigned, one bit a cycle
// depends on chd_pkg
module chd_mult (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [17:0]                  mcand,
    input  logic        [15:0]                  mplier,
    output logic                                done,
    output logic signed [chd_pkg::PROD_W-1:0]   prod
);
    logic signed [chd_pkg::PROD_W-1:0] mcand_reg, mcand_next;
    logic signed [chd_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [15:0] mplier_reg, mplier_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = chd_pkg::PROD_W'(mcand);
            acc_next    = '0;
            mplier_next = mplier;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = {1'b0, mplier_reg[15:1]};
            cnt_next    = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ===== rtl/chd_cordic.sv =====
// chd_cordic: iterative vectoring cordic for atan2, one micro-rotation a cycle
// depends on chd_pkg
module chd_cordic #(
    parameter int STEPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [chd_pkg::PROD_W-1:0]  x_in,
    input  logic signed [chd_pkg::PROD_W-1:0]  y_in,
    output logic                               done,
    output logic signed [chd_pkg::ANG_W-1:0]   angle
);
    logic signed [chd_pkg::VEC_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy, xs, ys;
    logic signed [chd_pkg::ANG_W-1:0] z_reg, z_next, da;
    logic [4:0] i_reg, i_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;

    always_comb begin
        xs = chd_pkg::VEC_W'(x_in);
        ys = chd_pkg::VEC_W'(y_in);
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        da = chd_pkg::ANG_W'(chd_pkg::atan_lut(i_reg));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            i_next = '0;
            if (x_in == '0 && y_in == '0) begin
                // zero vector gives angle zero, no rotations
                z_next    = '0;
                done_next = 1'b1;
            end else if (x_in < 0) begin
                x_next    = -xs;
                y_next    = -ys;
                z_next    = (y_in >= 0) ? chd_pkg::Z_180 : -chd_pkg::Z_180;
                busy_next = 1'b1;
            end else begin
                x_next    = xs;
                y_next    = ys;
                z_next    = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;
endmodule

// ===== rtl/chd_div.sv =====
// chd_div: restoring divider of the heading sum by the group size, one quotient bit a cycle
// depends on chd_pkg
module chd_div #(
    parameter int N = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [chd_pkg::SUM_W-1:0]  sum,
    output logic                              done,
    output logic signed [16:0]                quot
);
    localparam int RW = $clog2(N + 1) + 1;
    localparam int DW = chd_pkg::DVD_W;

    logic [DW-1:0] dvd_reg, dvd_next, mag;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW:0]   trial;
    logic          ge;
    logic          neg_reg, neg_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic signed [DW-1:0] s_ext;

    always_comb begin
        s_ext = DW'(sum);
        mag   = (sum < 0) ? DW'(-s_ext) : DW'(s_ext);
        trial = {rem_reg, dvd_reg[DW-1]};
        ge    = (trial >= (RW+1)'(N));
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // ties round away from zero on the magnitude
            dvd_next  = mag + DW'(N / 2);
            rem_next  = '0;
            neg_next  = (sum < 0);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? RW'(trial - (RW+1)'(N)) : RW'(trial);
            dvd_next = {dvd_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(dvd_reg[16:0]) : $signed(dvd_reg[16:0]);
endmodule
